// ===== hdl/hxd_pkg.sv =====
// Shared types and constants for the header/XOR packet deframer.
// No dependencies; used by every module in hdl/.
package hxd_pkg;

  localparam int unsigned HEADER_BYTES  = 13;
  localparam logic [7:0]  MIN_FRAME_LEN = 8'(HEADER_BYTES + 1);
  localparam logic [7:0]  MAX_LEN_RESET = 8'd50;
  localparam logic [8:0]  DBM_BIAS      = 9'd102;
  localparam logic [7:0]  LQI_MASK      = 8'h7F;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_BODY    = 2'd1,
    PH_STATUS1 = 2'd2,
    PH_STATUS2 = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_LEN_ERR  = 2'd1,
    VERDICT_CSUM_ERR = 2'd2
  } verdict_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         byte_index;
    logic [7:0]         data_byte;
    verdict_t           verdict;
    logic [7:0]         frame_length;
    logic signed [8:0]  signal_dbm;
    logic [6:0]         link_quality;
    logic               crc_ok;
    logic               flush_request;
  } result_t;

  function automatic logic signed [8:0] rssi_to_dbm(input logic [7:0] raw);
    logic signed [8:0] v;
    logic signed [8:0] half;
    v    = {raw[7], raw};
    half = (v + $signed({8'd0, v[8]})) >>> 1;
    return half - DBM_BIAS;
  endfunction

endpackage

// ===== hdl/hxd_frame.sv =====
// Frame parser: phase tracking, running XOR check and result formation.
// Depends on hxd_pkg.
module hxd_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         max_len,
  input  logic [7:0]         rx_byte,
  input  logic               go,
  output logic               has_result,
  output hxd_pkg::result_t   result
);

  hxd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] frame_len_r, frame_len_nxt;
  logic [7:0] body_pos_r, body_pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       csum_bad_r, csum_bad_nxt;
  logic [7:0] status1_r, status1_nxt;
  logic [8:0] pos_plus1;

  assign pos_plus1 = {1'b0, body_pos_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hxd_pkg::PH_LENGTH;
      frame_len_r <= '0;
      body_pos_r  <= '0;
      xor_r       <= '0;
      csum_bad_r  <= 1'b0;
      status1_r   <= '0;
    end else if (go) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      body_pos_r  <= body_pos_nxt;
      xor_r       <= xor_nxt;
      csum_bad_r  <= csum_bad_nxt;
      status1_r   <= status1_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    body_pos_nxt  = body_pos_r;
    xor_nxt       = xor_r;
    csum_bad_nxt  = csum_bad_r;
    status1_nxt   = status1_r;
    has_result    = 1'b0;
    result        = '0;
    unique case (phase_r)
      hxd_pkg::PH_LENGTH: begin
        if (rx_byte < hxd_pkg::MIN_FRAME_LEN || rx_byte > max_len) begin
          has_result           = 1'b1;
          result.kind          = hxd_pkg::KIND_VERDICT;
          result.verdict       = hxd_pkg::VERDICT_LEN_ERR;
          result.frame_length  = rx_byte;
          result.flush_request = 1'b1;
        end else begin
          frame_len_nxt = rx_byte;
          body_pos_nxt  = '0;
          xor_nxt       = '0;
          csum_bad_nxt  = 1'b0;
          phase_nxt     = hxd_pkg::PH_BODY;
        end
      end
      hxd_pkg::PH_BODY: begin
        if (pos_plus1 >= {1'b0, frame_len_r}) begin
          csum_bad_nxt = (rx_byte != xor_r);
          phase_nxt    = hxd_pkg::PH_STATUS1;
        end else begin
          has_result        = 1'b1;
          result.kind       = (body_pos_r < 8'(hxd_pkg::HEADER_BYTES)) ?
                              hxd_pkg::KIND_HEADER : hxd_pkg::KIND_PAYLOAD;
          result.byte_index = body_pos_r;
          result.data_byte  = rx_byte;
          xor_nxt           = xor_r ^ rx_byte;
          body_pos_nxt      = pos_plus1[7:0];
        end
      end
      hxd_pkg::PH_STATUS1: begin
        status1_nxt = rx_byte;
        phase_nxt   = hxd_pkg::PH_STATUS2;
      end
      hxd_pkg::PH_STATUS2: begin
        has_result           = 1'b1;
        result.kind          = hxd_pkg::KIND_VERDICT;
        result.verdict       = csum_bad_r ? hxd_pkg::VERDICT_CSUM_ERR : hxd_pkg::VERDICT_OK;
        result.frame_length  = frame_len_r;
        result.signal_dbm    = hxd_pkg::rssi_to_dbm(status1_r);
        result.link_quality  = 7'(rx_byte & hxd_pkg::LQI_MASK);
        result.crc_ok        = rx_byte[7];
        result.flush_request = csum_bad_r;
        phase_nxt            = hxd_pkg::PH_LENGTH;
      end
      default: begin
        phase_nxt = hxd_pkg::PH_LENGTH;
      end
    endcase
  end

endmodule

// ===== hdl/hxd_out_buf.sv =====
// Two-entry result buffer: a circular buffer with read and write pointers.
// Depends on hxd_pkg.
module hxd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hxd_pkg::result_t   push_data,
  output logic               has_space,
  output logic               out_valid,
  input  logic               out_ready,
  output hxd_pkg::result_t   out_data
);

  hxd_pkg::result_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign has_space = (cnt_r != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/header_xor_packet_deframer.sv =====
// Header/XOR packet deframer: takes receive FIFO bytes one per transfer and
// emits header bytes, payload bytes and one verdict per frame (length error,
// checksum error or ok, with RSSI in dBm, LQI and CRC-ok). One byte is taken
// per cycle while the result buffer has space; a byte passes an input register,
// the frame parser and a two-entry result buffer.
// Input stalls only while the result buffer holds two untaken results.
// Depends on hxd_pkg, hxd_frame and hxd_out_buf.
module header_xor_packet_deframer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte_index,
  output logic [7:0]        out_data_byte,
  output logic [1:0]        out_verdict,
  output logic [7:0]        out_frame_length,
  output logic signed [8:0] out_signal_dbm,
  output logic [6:0]        out_link_quality,
  output logic              out_crc_ok,
  output logic              out_flush_request
);

  logic [7:0]       max_len_r;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             go;
  logic             has_result;
  logic             has_space;
  hxd_pkg::result_t result;
  hxd_pkg::result_t out_data;

  assign go       = s1_valid_r && has_space;
  assign in_ready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= hxd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  hxd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_len    (max_len_r),
    .rx_byte    (s1_byte_r),
    .go         (go),
    .has_result (has_result),
    .result     (result)
  );

  hxd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go && has_result),
    .push_data (result),
    .has_space (has_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind          = out_data.kind;
  assign out_byte_index    = out_data.byte_index;
  assign out_data_byte     = out_data.data_byte;
  assign out_verdict       = out_data.verdict;
  assign out_frame_length  = out_data.frame_length;
  assign out_signal_dbm    = out_data.signal_dbm;
  assign out_link_quality  = out_data.link_quality;
  assign out_crc_ok        = out_data.crc_ok;
  assign out_flush_request = out_data.flush_request;

endmodule
